// File: rtl/core/msv_pkg.sv
`timescale 1ns / 1ps

package msv_pkg;

    // Build settings
    localparam int SAMPLE_RATE     = 48000;
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int PHASE_WIDTH     = 32;

    localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);
    localparam int SINE_QTR  = SINE_TABLE_SIZE / 4;

    localparam int AMP_W  = 17;
    localparam int NOTE_W = 7;
    localparam int WAVE_W = 17;
    localparam int G_W    = 18;
    localparam int MULA_W = 19;
    localparam int MULB_W = 18;
    localparam int PROD_W = MULA_W + MULB_W;

    localparam logic [AMP_W-1:0] AMP_ONE = 17'h10000;
    localparam logic [AMP_W-1:0] AMP_ZERO = 17'h00000;
    localparam logic [NOTE_W-1:0] NOTE_A4 = 7'd69;

    localparam logic signed [WAVE_W-1:0] WAVE_POS = 17'sd32768;
    localparam logic signed [WAVE_W-1:0] WAVE_NEG = -17'sd32768;

    localparam longint Q30 = 64'sd1073741824;

    // Note increment scaling
    localparam int     INC_SHL = (PHASE_WIDTH >= 21) ? PHASE_WIDTH - 21 : 0;
    localparam longint INC_DEN = (PHASE_WIDTH >= 21) ? longint'(SAMPLE_RATE)
                                 : longint'(SAMPLE_RATE) << (21 - PHASE_WIDTH);

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_NOTE_ON  = 2'd1,
        REQ_NOTE_OFF = 2'd2,
        REQ_ALL_OFF  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave_sel;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DOWN = 2'd1,
        MODE_UP   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_WAVE_SELECT       = 3'd0,
        CFG_ATTACK_STEP       = 3'd1,
        CFG_RELEASE_STEP      = 3'd2,
        CFG_TRANSITION_STEP   = 3'd3,
        CFG_OUTPUT_GAIN       = 3'd4,
        CFG_SILENCE_THRESHOLD = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_TRANS,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [NOTE_W-1:0] note_number;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               voice_active;
    } t_out_item;

    typedef struct packed {
        logic                     en;
        logic signed [MULA_W-1:0] a;
        logic signed [MULB_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic [AMP_W-1:0] target;
        logic [AMP_W-1:0] step;
    } t_env_req;

    typedef logic [127:0][PHASE_WIDTH-1:0] t_inc_tbl;
    typedef logic [SINE_QTR-1:0][15:0]     t_sine_tbl;

    function automatic longint f16_of(input int k);
        longint f;
        case (k)
            0:       f = 64'd17145893;
            1:       f = 64'd18165441;
            2:       f = 64'd19245614;
            3:       f = 64'd20390018;
            4:       f = 64'd21602472;
            5:       f = 64'd22887021;
            6:       f = 64'd24247954;
            7:       f = 64'd25689813;
            8:       f = 64'd27217409;
            9:       f = 64'd28835840;
            10:      f = 64'd30550508;
            default: f = 64'd32367136;
        endcase
        return f;
    endfunction

    function automatic t_inc_tbl build_inc_tbl();
        t_inc_tbl tbl;
        longint   num;
        for (int n = 0; n < 128; n++) begin
            num = (f16_of(n % 12) << (n / 12)) << INC_SHL;
            tbl[n] = PHASE_WIDTH'((num + INC_DEN / 2) / INC_DEN);
        end
        return tbl;
    endfunction

    // Odd polynomial up to degree 9, Q30 coefficients, truncating products
    function automatic logic [15:0] quarter_sine(input longint s);
        longint z;
        longint p;
        longint v;
        z = (s * s) >>> 2;
        p = 64'sd172272;
        p = -64'sd5026995 + p * z / Q30;
        p = 64'sd85569306 + p * z / Q30;
        p = -64'sd693598668 + p * z / Q30;
        p = 64'sd1686629713 + p * z / Q30;
        v = p * s / 64'sd65536;
        if (v < 0) begin
            v = 0;
        end
        v = (v + 64'sd16384) / 64'sd32768;
        if (v > 64'sd32768) begin
            v = 64'sd32768;
        end
        return 16'(v);
    endfunction

    function automatic t_sine_tbl build_sine_tbl();
        t_sine_tbl tbl;
        longint    t;
        for (int j = 0; j < SINE_QTR; j++) begin
            t = (longint'(j) * 64'sd262144) / SINE_TABLE_SIZE;
            tbl[j] = quarter_sine(t);
        end
        return tbl;
    endfunction

    localparam t_inc_tbl  INC_TBL   = build_inc_tbl();
    localparam t_sine_tbl SINE_TBL  = build_sine_tbl();
    localparam logic [15:0] SINE_PEAK = quarter_sine(64'sd65536);
    localparam logic [PHASE_WIDTH-1:0] PHASE_STEP_RESET = INC_TBL[NOTE_A4];

endpackage

// File: rtl/core/msv_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier, product registered and held when idle
module msv_mul (
    input  logic                                 i_clk,
    input  msv_pkg::t_mul_req                    i_req,
    output logic signed [msv_pkg::PROD_W-1:0]    o_prod
);

    logic signed [msv_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/msv_env.sv
`timescale 1ns / 1ps

// Linear step toward target, clamp on arrival
module msv_env (
    input  logic [msv_pkg::AMP_W-1:0] i_amp,
    input  msv_pkg::t_env_req         i_req,
    output logic [msv_pkg::AMP_W-1:0] o_amp
);

    logic [msv_pkg::AMP_W-1:0] up_diff;
    logic [msv_pkg::AMP_W-1:0] dn_diff;
    logic [msv_pkg::AMP_W:0]   up_sum;

    always_comb begin
        up_diff = i_req.target - i_amp;
        dn_diff = i_amp - i_req.target;
        up_sum  = {1'b0, i_amp} + {1'b0, i_req.step};
        if (i_amp < i_req.target) begin
            o_amp = (up_diff <= i_req.step) ? i_req.target : up_sum[msv_pkg::AMP_W-1:0];
        end else if (i_amp > i_req.target) begin
            o_amp = (dn_diff <= i_req.step) ? i_req.target : i_amp - i_req.step;
        end else begin
            o_amp = i_amp;
        end
    end

endmodule

// File: rtl/core/msv_wave.sv
`timescale 1ns / 1ps

// Oscillator shape from the phase accumulator
module msv_wave (
    input  logic [msv_pkg::PHASE_WIDTH-1:0]   i_phase,
    input  logic [1:0]                        i_sel,
    output logic signed [msv_pkg::WAVE_W-1:0] o_wave
);

    localparam int SB = msv_pkg::SINE_BITS;
    localparam logic signed [msv_pkg::WAVE_W-1:0] WAVE_POS_C = msv_pkg::WAVE_POS;

    logic [15:0]                      frac;
    logic [SB-1:0]                    idx;
    logic [SB-3:0]                    lo;
    logic [SB-2:0]                    qidx;
    logic [15:0]                      mag;
    logic signed [msv_pkg::WAVE_W:0]  f_ext;
    logic signed [msv_pkg::WAVE_W:0]  fold_dist;
    logic signed [msv_pkg::WAVE_W:0]  tri_v;
    logic signed [msv_pkg::WAVE_W-1:0] sine_v;

    always_comb begin
        frac  = i_phase[msv_pkg::PHASE_WIDTH-1 -: 16];
        idx   = i_phase[msv_pkg::PHASE_WIDTH-1 -: SB];
        lo    = idx[SB-3:0];
        // fold the odd quadrants back onto the first quarter
        qidx  = idx[SB-2] ? (SB-1)'(msv_pkg::SINE_QTR) - {1'b0, lo} : {1'b0, lo};
        mag   = qidx[SB-2] ? msv_pkg::SINE_PEAK : msv_pkg::SINE_TBL[qidx[SB-3:0]];
        sine_v = idx[SB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        f_ext     = $signed({2'b00, frac});
        fold_dist = frac[15] ? f_ext - 18'sd32768 : 18'sd32768 - f_ext;
        tri_v     = 18'sd32768 - (fold_dist <<< 1);

        case (i_sel)
            msv_pkg::WAVE_SINE:     o_wave = sine_v;
            msv_pkg::WAVE_SAW:      o_wave = $signed({1'b0, frac}) - WAVE_POS_C;
            msv_pkg::WAVE_SQUARE:   o_wave = frac[15] ? msv_pkg::WAVE_NEG : msv_pkg::WAVE_POS;
            default:                o_wave = tri_v[msv_pkg::WAVE_W-1:0];
        endcase
    end

endmodule

// File: rtl/core/mono_synth_voice.sv
`timescale 1ns / 1ps

// Monophonic synth voice: phase accumulator oscillator with linear envelope.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is a
// sample tick, note on, note off or all notes off. Only a tick returns a
// transaction on the output channel (o_out_valid / i_out_stall / o_out_data),
// carrying the saturated 16-bit sample and the voice-active flag.
// Note events finish in the cycle they are accepted and return nothing.
// A tick runs five steps on one shared multiplier and envelope unit:
// envelope move, note transition, gain*amplitude, times waveform, round and
// saturate. Its result is registered once the last step completes (a silent
// voice ends early with a zero sample); o_in_stall stays high meanwhile, so
// the next tick is accepted only after the voice returns to idle.
// The output register lets the next transaction be accepted while a result
// waits; a tick that finishes while the receiver stalls holds its last step.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered
// and are meant for an idle voice. Synchronous reset restores the register
// defaults, silences the voice and loads the 440 Hz increment.
module mono_synth_voice (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  msv_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msv_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [16:0]         i_cfg_data
);

    localparam int AW = msv_pkg::AMP_W;
    localparam int NW = msv_pkg::NOTE_W;
    localparam int PW = msv_pkg::PHASE_WIDTH;
    localparam int XW = msv_pkg::PROD_W;

    // configuration
    logic [1:0]    r_wave_sel;
    logic [AW-1:0] r_attack;
    logic [AW-1:0] r_release;
    logic [AW-1:0] r_trans_step;
    logic [AW-1:0] r_gain;
    logic [AW-1:0] r_thr;

    // voice state
    msv_pkg::t_state r_state, n_state;
    msv_pkg::t_mode  r_mode, n_mode;
    logic [AW-1:0]   r_amp, n_amp;
    logic [PW-1:0]   r_phase, n_phase;
    logic [PW-1:0]   r_step, n_step;
    logic            r_gate, n_gate;
    logic [NW-1:0]   r_cur, n_cur;
    logic            r_cur_vld, n_cur_vld;
    logic [NW-1:0]   r_pend, n_pend;
    logic            r_pend_vld, n_pend_vld;
    logic            r_rst_phase, n_rst_phase;

    logic               r_out_valid, n_out_valid;
    msv_pkg::t_out_item r_out_data, n_out_data;

    msv_pkg::t_mul_req  mul_req;
    logic signed [XW-1:0] prod;
    msv_pkg::t_env_req  env_req;
    logic [AW-1:0]      env_amp;
    logic signed [msv_pkg::WAVE_W-1:0] wave;

    logic          accept;
    logic          out_free;
    logic          ramp;
    logic          active;
    logic          neg;
    logic [XW-1:0] mag;
    logic [XW-1:0] rnd;
    logic [15:0]   sample;
    logic [AW:0]   up_sum;

    msv_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    msv_env u_env (
        .i_amp (r_amp),
        .i_req (env_req),
        .o_amp (env_amp)
    );

    msv_wave u_wave (
        .i_phase (r_phase),
        .i_sel   (r_wave_sel),
        .o_wave  (wave)
    );

    assign o_in_stall  = (r_state != msv_pkg::ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // envelope target and step: transition ramp overrides the gate
    always_comb begin
        ramp = (r_mode == msv_pkg::MODE_DOWN) || (r_mode == msv_pkg::MODE_UP);
        if (ramp) begin
            env_req.target = (r_mode == msv_pkg::MODE_DOWN) ? msv_pkg::AMP_ZERO
                                                           : msv_pkg::AMP_ONE;
            env_req.step   = r_trans_step;
        end else begin
            env_req.target = r_gate ? msv_pkg::AMP_ONE : msv_pkg::AMP_ZERO;
            env_req.step   = r_gate ? r_attack : r_release;
        end
    end

    // round half away from zero, then saturate to 16 bits
    always_comb begin
        neg = prod[XW-1];
        mag = neg ? XW'(-prod) : XW'(prod);
        rnd = (mag + XW'(32768)) >> 16;
        if (!neg) begin
            sample = (rnd > XW'(32767)) ? 16'h7FFF : rnd[15:0];
        end else begin
            sample = (rnd > XW'(32768)) ? 16'h8000 : 16'(-rnd[15:0]);
        end
    end

    assign active = r_gate || (r_amp > r_thr);
    assign up_sum = {1'b0, r_amp} + {1'b0, r_thr};

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_amp       = r_amp;
        n_phase     = r_phase;
        n_step      = r_step;
        n_gate      = r_gate;
        n_cur       = r_cur;
        n_cur_vld   = r_cur_vld;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        n_rst_phase = r_rst_phase;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        mul_req.en  = 1'b0;
        mul_req.a   = $signed({2'b00, r_gain});
        mul_req.b   = $signed({1'b0, r_amp});

        case (r_state)
            msv_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in_data.req_type)
                        msv_pkg::REQ_TICK: begin
                            n_state = msv_pkg::ST_ENV;
                        end
                        msv_pkg::REQ_NOTE_ON: begin
                            if (r_amp > r_thr) begin
                                // still audible: ramp down, swap later
                                n_pend      = i_in_data.note_number;
                                n_pend_vld  = 1'b1;
                                n_rst_phase = 1'b1;
                                n_gate      = 1'b0;
                                n_mode      = msv_pkg::MODE_DOWN;
                            end else begin
                                n_cur       = i_in_data.note_number;
                                n_cur_vld   = 1'b1;
                                n_phase     = '0;
                                n_gate      = 1'b1;
                                n_mode      = msv_pkg::MODE_NONE;
                                n_pend_vld  = 1'b0;
                                n_rst_phase = 1'b0;
                                n_step      = msv_pkg::INC_TBL[i_in_data.note_number];
                            end
                        end
                        msv_pkg::REQ_NOTE_OFF: begin
                            if (r_cur_vld && i_in_data.note_number == r_cur) begin
                                n_gate = 1'b0;
                                if (r_mode == msv_pkg::MODE_UP) begin
                                    n_mode = msv_pkg::MODE_NONE;
                                end
                            end
                            if (r_pend_vld && i_in_data.note_number == r_pend) begin
                                n_pend_vld = 1'b0;
                                if (r_mode == msv_pkg::MODE_DOWN) begin
                                    n_mode = msv_pkg::MODE_NONE;
                                end
                            end
                        end
                        default: begin
                            n_gate = 1'b0;
                            n_mode = msv_pkg::MODE_NONE;
                        end
                    endcase
                end
            end
            msv_pkg::ST_ENV: begin
                n_amp   = env_amp;
                n_state = msv_pkg::ST_TRANS;
            end
            msv_pkg::ST_TRANS: begin
                if (r_mode == msv_pkg::MODE_DOWN && r_amp <= r_thr) begin
                    // silent enough: swap to the pending note and ramp up
                    n_amp     = '0;
                    n_cur     = r_pend;
                    n_cur_vld = r_pend_vld;
                    if (r_pend_vld) begin
                        n_step = msv_pkg::INC_TBL[r_pend];
                    end
                    if (r_rst_phase) begin
                        n_phase = '0;
                    end
                    n_gate = 1'b1;
                    n_mode = msv_pkg::MODE_UP;
                end else if (r_mode == msv_pkg::MODE_UP &&
                             up_sum >= {1'b0, msv_pkg::AMP_ONE}) begin
                    n_mode = msv_pkg::MODE_NONE;
                end
                n_state = msv_pkg::ST_MUL1;
            end
            msv_pkg::ST_MUL1: begin
                if (active) begin
                    // gain times amplitude
                    mul_req.en = 1'b1;
                    n_state    = msv_pkg::ST_MUL2;
                end else if (out_free) begin
                    // silent voice: drop the level, emit zero
                    n_amp                   = '0;
                    n_out_valid             = 1'b1;
                    n_out_data.sample_out   = '0;
                    n_out_data.voice_active = 1'b0;
                    n_state                 = msv_pkg::ST_IDLE;
                end
            end
            msv_pkg::ST_MUL2: begin
                // scaled gain times waveform
                mul_req.en = 1'b1;
                mul_req.a  = $signed({1'b0, prod[msv_pkg::G_W+15:16]});
                mul_req.b  = $signed({wave[msv_pkg::WAVE_W-1], wave});
                n_state    = msv_pkg::ST_FIN;
            end
            msv_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.sample_out   = $signed(sample);
                    n_out_data.voice_active = 1'b1;
                    n_phase                 = r_phase + r_step;
                    n_state                 = msv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = msv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msv_pkg::ST_IDLE;
            r_mode      <= msv_pkg::MODE_NONE;
            r_amp       <= '0;
            r_phase     <= '0;
            r_step      <= msv_pkg::PHASE_STEP_RESET;
            r_gate      <= 1'b0;
            r_cur       <= '0;
            r_cur_vld   <= 1'b0;
            r_pend      <= '0;
            r_pend_vld  <= 1'b0;
            r_rst_phase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_amp       <= n_amp;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_gate      <= n_gate;
            r_cur       <= n_cur;
            r_cur_vld   <= n_cur_vld;
            r_pend      <= n_pend;
            r_pend_vld  <= n_pend_vld;
            r_rst_phase <= n_rst_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result payload until it is taken
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel   <= msv_pkg::WAVE_SINE;
            r_attack     <= 17'd15;
            r_release    <= 17'd3;
            r_trans_step <= 17'd149;
            r_gain       <= 17'd32768;
            r_thr        <= 17'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msv_pkg::CFG_WAVE_SELECT:       r_wave_sel   <= i_cfg_data[1:0];
                msv_pkg::CFG_ATTACK_STEP:       r_attack     <= i_cfg_data;
                msv_pkg::CFG_RELEASE_STEP:      r_release    <= i_cfg_data;
                msv_pkg::CFG_TRANSITION_STEP:   r_trans_step <= i_cfg_data;
                msv_pkg::CFG_OUTPUT_GAIN:       r_gain       <= i_cfg_data;
                msv_pkg::CFG_SILENCE_THRESHOLD: r_thr        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_up_gate_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == msv_pkg::MODE_UP) |-> r_gate)
        else $error("ramp up with gate closed");

    a_down_gate_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == msv_pkg::MODE_DOWN) |-> !r_gate)
        else $error("ramp down with gate open");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.voice_active) |-> (o_out_data.sample_out == 16'sd0))
        else $error("inactive voice gave a nonzero sample");

    a_event_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.req_type != msv_pkg::REQ_TICK && !o_out_valid)
        |=> !o_out_valid)
        else $error("note event produced a result");
`endif

endmodule
